// ===== hw/rtl/wapf_pkg.sv =====
// Package for the wearable activity power manager: field widths, mode and command codes,
// enable flag masks and reset constants.
// No dependencies; every other file of the block imports it.
package wapf_pkg;

   // time base and field widths
   localparam int TIME_WIDTH = 32;
   localparam int CMD_W      = 3;
   localparam int IDLE_W     = 32;
   localparam int SEC_W      = 12;
   localparam int MSK_W      = 10;
   localparam int MS_W       = 22;
   localparam int TOT_W      = 32;
   localparam int FLAG_W     = 4;

   // timeout constants
   localparam logic [SEC_W-1:0] TIMEOUT_S_RESET  = 12'd20;
   localparam logic [MSK_W-1:0] MS_PER_S         = 10'd1000;
   localparam logic [MS_W-1:0]  TIMEOUT_MS_RESET = 22'd20000;

   // power modes
   typedef enum logic [1:0] {
      MODE_ACTIVE     = 2'd0,
      MODE_INACTIVE   = 2'd1,
      MODE_STATIONARY = 2'd2
   } mode_type;

   // item commands
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 3'd0,
      CMD_USER       = 3'd1,
      CMD_WRIST      = 3'd2,
      CMD_NO_MOTION  = 3'd3,
      CMD_ANY_MOTION = 3'd4
   } cmd_type;

   // enable flag bits
   typedef logic [FLAG_W-1:0] flags_type;
   localparam flags_type EN_POWER  = 4'b0001;
   localparam flags_type EN_WAKE   = 4'b0010;
   localparam flags_type EN_NOMOT  = 4'b0100;
   localparam flags_type EN_ANYMOT = 4'b1000;
   localparam int FLAG_POWER  = 0;
   localparam int FLAG_WAKE   = 1;
   localparam int FLAG_NOMOT  = 2;
   localparam int FLAG_ANYMOT = 3;

endpackage

// ===== hw/rtl/wapf_req_if.sv =====
// Request channel of the activity power manager: valid/ready plus the input item fields.
// Depends on wapf_pkg for field widths.
interface wapf_req_if
   import wapf_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [IDLE_W-1:0] ui_idle_ms;

   modport source (output valid, output command, output ui_idle_ms, input ready);
   modport sink   (input valid, input command, input ui_idle_ms, output ready);
endinterface

// ===== hw/rtl/wapf_rsp_if.sv =====
// Response channel of the activity power manager: valid/ready plus the result item fields.
// Depends on wapf_pkg for field widths.
interface wapf_rsp_if
   import wapf_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [1:0]       power_state;
   logic             display_power_on;
   logic             display_wake_on;
   logic             no_motion_detect_on;
   logic             any_motion_detect_on;
   logic             woke_up;
   logic             state_changed;
   logic [MS_W-1:0]  ms_to_inactive;
   logic [TOT_W-1:0] awake_total_out;
   logic [TOT_W-1:0] display_off_total_out;

   modport source (
      output valid, input ready,
      output power_state, output display_power_on, output display_wake_on,
      output no_motion_detect_on, output any_motion_detect_on, output woke_up,
      output state_changed, output ms_to_inactive, output awake_total_out,
      output display_off_total_out
   );
   modport sink (
      input valid, output ready,
      input power_state, input display_power_on, input display_wake_on,
      input no_motion_detect_on, input any_motion_detect_on, input woke_up,
      input state_changed, input ms_to_inactive, input awake_total_out,
      input display_off_total_out
   );
endinterface

// ===== hw/rtl/wearable_activity_power_fsm.sv =====
// Activity power manager of a wearable: mode machine, idle countdown, uptime and totals.
// An item goes to the input register, then its result to the result register until taken.
// Throughput: one item per cycle while results are taken; the result register frees as taken.
// Reset (synchronous, active high): mode active, timeout 20 s, idle countdown at the timeout,
// other counters and totals zero, display power and wake on, detectors off, both stages
// empty; needs wapf_pkg and the channels.
module wearable_activity_power_fsm
   import wapf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   wapf_req_if.sink          req_chan,
   wapf_rsp_if.source        rsp_chan,
   input  logic              csr_write_en,
   input  logic [SEC_W-1:0]  csr_write_data
);

   // pipeline control
   logic              s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [IDLE_W-1:0] s1_idle_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              advance;
   logic              fire;
   logic              req_take;

   // block state
   mode_type           mode_ff, mode_in;
   logic [MS_W-1:0]    tms_ff, tms_in;
   logic [TIME_WIDTH-1:0] uptime_ff, uptime_in;
   logic [TIME_WIDTH-1:0] wake_start_ff, wake_start_in;
   logic [TIME_WIDTH-1:0] off_start_ff, off_start_in;
   logic [MS_W-1:0]    idle_rem_ff, idle_rem_in;
   logic [TOT_W-1:0]   awake_tot_ff, awake_tot_in;
   logic [TOT_W-1:0]   off_tot_ff, off_tot_in;
   flags_type          flags_ff, flags_in;

   // result register
   logic [MS_W-1:0]    to_inact_ff, to_inact_in;
   logic               woke_ff, woke_in;
   logic               changed_ff, changed_in;

   // decode helpers
   logic                  awake_now;
   logic                  ui_gt_tms;
   logic                  ui_lt_tms;
   logic                  rem_gt_one;
   logic                  wake_entry;
   logic [MS_W-1:0]       gap;
   logic [TIME_WIDTH-1:0] wake_span;
   logic [TIME_WIDTH-1:0] off_span;
   logic [SEC_W+MSK_W-1:0] tms_prod;

   // handshake
   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign fire     = s1_valid_ff && advance;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // timeout in ms, converted once at configuration write
   assign tms_prod = csr_write_data * MS_PER_S;
   assign tms_in   = csr_write_en ? tms_prod[MS_W-1:0] : tms_ff;

   // shared compares and spans
   assign awake_now  = (mode_ff == MODE_ACTIVE);
   assign ui_gt_tms  = s1_idle_ff > IDLE_W'(tms_ff);
   assign ui_lt_tms  = s1_idle_ff < IDLE_W'(tms_ff);
   assign rem_gt_one = idle_rem_ff > MS_W'(1);
   assign gap        = MS_W'(IDLE_W'(tms_ff) - s1_idle_ff);
   assign wake_span  = uptime_in - wake_start_ff;
   assign off_span   = uptime_in - off_start_ff;

   always_comb begin
      wake_entry = 1'b0;
      case (cmd_type'(s1_cmd_ff))
         CMD_USER, CMD_WRIST: wake_entry = !awake_now;
         default:             wake_entry = 1'b0;
      endcase
   end

   // next mode
   always_comb begin
      mode_in = mode_ff;
      case (cmd_type'(s1_cmd_ff))
         CMD_TICK: begin
            if (awake_now && !rem_gt_one && ui_gt_tms) begin
               mode_in = MODE_INACTIVE;
            end
         end
         CMD_USER, CMD_WRIST: begin
            if (!awake_now) begin
               mode_in = MODE_ACTIVE;
            end
         end
         CMD_NO_MOTION: begin
            if (!awake_now) begin
               mode_in = MODE_STATIONARY;
            end
         end
         CMD_ANY_MOTION: begin
            if (!awake_now) begin
               mode_in = MODE_INACTIVE;
            end
         end
         default: mode_in = mode_ff;
      endcase
   end

   // counters, totals, enables and item flags
   always_comb begin
      uptime_in     = uptime_ff;
      wake_start_in = wake_start_ff;
      off_start_in  = off_start_ff;
      idle_rem_in   = idle_rem_ff;
      awake_tot_in  = awake_tot_ff;
      off_tot_in    = off_tot_ff;
      flags_in      = flags_ff;
      woke_in       = 1'b0;
      changed_in    = 1'b0;
      if (cmd_type'(s1_cmd_ff) == CMD_TICK) begin
         uptime_in = uptime_ff + TIME_WIDTH'(1);
      end
      case (cmd_type'(s1_cmd_ff))
         CMD_TICK: begin
            if (awake_now) begin
               if (rem_gt_one) begin
                  idle_rem_in = idle_rem_ff - MS_W'(1);
               end else if (ui_gt_tms) begin
                  awake_tot_in = awake_tot_ff + TOT_W'(wake_span);
                  flags_in     = (flags_ff & EN_POWER) | EN_NOMOT;
                  changed_in   = 1'b1;
               end else begin
                  idle_rem_in = gap;
               end
            end
         end
         CMD_USER: begin
            woke_in    = !awake_now;
            changed_in = !awake_now;
            if (awake_now) begin
               idle_rem_in = tms_ff;
            end
         end
         CMD_WRIST: begin
            changed_in = !awake_now;
         end
         CMD_NO_MOTION: begin
            if (!awake_now) begin
               off_start_in = uptime_ff;
               flags_in     = (flags_ff & EN_WAKE) | EN_ANYMOT;
               changed_in   = 1'b1;
            end
         end
         CMD_ANY_MOTION: begin
            if (!awake_now) begin
               off_tot_in = off_tot_ff + TOT_W'(off_span);
               flags_in   = (flags_ff & EN_WAKE) | EN_POWER | EN_NOMOT;
               changed_in = 1'b1;
            end
         end
         default: changed_in = 1'b0;
      endcase
      // wakeup into active from inactive or stationary
      if (wake_entry) begin
         if (mode_ff == MODE_STATIONARY) begin
            off_tot_in = off_tot_ff + TOT_W'(off_span);
         end
         wake_start_in = uptime_ff;
         flags_in      = EN_POWER | EN_WAKE;
         idle_rem_in   = tms_ff;
      end
   end

   // time left until inactive, from the updated countdown
   always_comb begin
      to_inact_in = '0;
      if (mode_in == MODE_ACTIVE) begin
         to_inact_in = idle_rem_in;
         if (ui_lt_tms && (gap > idle_rem_in)) begin
            to_inact_in = gap;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mode_ff       <= MODE_ACTIVE;
         tms_ff        <= TIMEOUT_MS_RESET;
         uptime_ff     <= '0;
         wake_start_ff <= '0;
         off_start_ff  <= '0;
         idle_rem_ff   <= TIMEOUT_MS_RESET;
         awake_tot_ff  <= '0;
         off_tot_ff    <= '0;
         flags_ff      <= EN_POWER | EN_WAKE;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         tms_ff       <= tms_in;
         if (fire) begin
            mode_ff       <= mode_in;
            uptime_ff     <= uptime_in;
            wake_start_ff <= wake_start_in;
            off_start_ff  <= off_start_in;
            idle_rem_ff   <= idle_rem_in;
            awake_tot_ff  <= awake_tot_in;
            off_tot_ff    <= off_tot_in;
            flags_ff      <= flags_in;
         end
      end
   end

   // input and result payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_cmd_ff  <= req_chan.command;
         s1_idle_ff <= req_chan.ui_idle_ms;
      end
      if (fire) begin
         to_inact_ff <= to_inact_in;
         woke_ff     <= woke_in;
         changed_ff  <= changed_in;
      end
   end

   // result outputs; the totals, mode and enables are the registered state itself
   assign rsp_chan.valid                 = rsp_valid_ff;
   assign rsp_chan.power_state           = mode_ff;
   assign rsp_chan.display_power_on      = flags_ff[FLAG_POWER];
   assign rsp_chan.display_wake_on       = flags_ff[FLAG_WAKE];
   assign rsp_chan.no_motion_detect_on   = flags_ff[FLAG_NOMOT];
   assign rsp_chan.any_motion_detect_on  = flags_ff[FLAG_ANYMOT];
   assign rsp_chan.woke_up               = woke_ff;
   assign rsp_chan.state_changed         = changed_ff;
   assign rsp_chan.ms_to_inactive        = to_inact_ff;
   assign rsp_chan.awake_total_out       = awake_tot_ff;
   assign rsp_chan.display_off_total_out = off_tot_ff;

   // active mode always has display power and wake on, detectors off
   a_active_flags: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ACTIVE |-> flags_ff == (EN_POWER | EN_WAKE))
      else $error("active mode with wrong enables");

   // stationary mode has the display regulator off and any-motion armed
   a_stationary_flags: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_STATIONARY |-> !flags_ff[FLAG_POWER] && flags_ff[FLAG_ANYMOT])
      else $error("stationary mode with wrong enables");

   // a wakeup report always lands in active mode
   a_woke_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && woke_ff |-> mode_ff == MODE_ACTIVE)
      else $error("woke_up without active mode");

   // countdown report is zero outside active mode
   a_to_inact_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && mode_ff != MODE_ACTIVE |-> to_inact_ff == '0)
      else $error("ms_to_inactive nonzero while not active");

   // a stalled input item stays in the input register
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_cmd_ff))
      else $error("input item lost while stalled");

endmodule
